// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL; they compile away under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked property, checked outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Clocked property, checked during reset as well.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/bpcl_pkg.sv =====
// Shared constants and types of the BSP point cell locator.
package bpcl_pkg;

  // Table size and coordinate format
  localparam int MAX_NODES  = 1024;
  localparam int COORD_BITS = 32;
  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int CNT_W      = $clog2(MAX_NODES + 1);
  localparam int FRAC_BITS  = 16;

  // Field widths
  localparam int NORM_W   = 18;
  localparam int OFS_W    = 32;
  localparam int LINK_W   = 11;
  localparam int RAD_W    = 31;
  localparam int STATUS_W = 3;
  localparam int CELL_W   = 10;

  // Plane test arithmetic
  localparam int PROD_W = NORM_W + COORD_BITS;
  localparam int OFR_W  = OFS_W + 1;
  localparam int DIST_W = PROD_W + 3;

  // Item commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_WRITE = 3'd0,
    ST_FOUND = 3'd1,
    ST_ZERO  = 3'd2,
    ST_EMPTY = 3'd3,
    ST_LIMIT = 3'd4
  } status_t;

  // One node table entry
  typedef struct packed {
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
    logic        [OFS_W-1:0]  plane_offset;
    logic signed [LINK_W-1:0] front_link;
    logic signed [LINK_W-1:0] back_link;
  } node_t;

endpackage

// ===== rtl/bpcl_if.sv =====
// Item channels of the BSP point cell locator: request and response.
interface bpcl_req_if import bpcl_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [NODE_W-1:0]            node_index;
  logic signed [NORM_W-1:0]     normal_x;
  logic signed [NORM_W-1:0]     normal_y;
  logic signed [NORM_W-1:0]     normal_z;
  logic signed [OFS_W-1:0]      plane_offset;
  logic signed [LINK_W-1:0]     front_link;
  logic signed [LINK_W-1:0]     back_link;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;
  logic [RAD_W-1:0]             radius;

  modport source (
    output valid, cmd, node_index, normal_x, normal_y, normal_z, plane_offset,
           front_link, back_link, point_x, point_y, point_z, radius,
    input  ready
  );
  modport sink (
    input  valid, cmd, node_index, normal_x, normal_y, normal_z, plane_offset,
           front_link, back_link, point_x, point_y, point_z, radius,
    output ready
  );
endinterface

interface bpcl_rsp_if import bpcl_pkg::*; ();
  logic              valid;
  logic              ready;
  status_t           status;
  logic [CELL_W-1:0] cell_index;
  logic [CNT_W-1:0]  walk_depth;

  modport source (output valid, status, cell_index, walk_depth, input ready);
  modport sink (input valid, status, cell_index, walk_depth, output ready);
endinterface

// ===== rtl/bsp_point_cell_locate.sv =====
// Top level: BSP node table and the tree walk that locates a point's cell.
// Write item: result registered, else held in S_HOLD; one item per cycle if rsp free.
// Query: four steps per node (table read, multiply, partial sums, decide);
//   a walk limit hit ends the walk in the table read step.
// The single-port node table read sets the pace; the next item is taken once
//   the result is in the response register, while it may still wait on rsp.
// Reset clears control and node_count; the node table keeps undefined data.
`include "assert_macros.svh"

module bsp_point_cell_locate import bpcl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  bpcl_req_if.sink            req,
  bpcl_rsp_if.source          rsp,
  input  logic                cfg_we,
  input  logic [CNT_W-1:0]    cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_MUL,
    S_ADD,
    S_DEC,
    S_HOLD
  } state_t;

  state_t state;

  // Node table
  node_t              mem [MAX_NODES];
  node_t              rd_data;
  logic               mem_we;
  node_t              mem_wdata;

  // Configuration and walk registers
  logic [CNT_W-1:0]             node_count;
  logic [CNT_W-1:0]             limit;
  logic [CNT_W-1:0]             limit_q;
  logic [CNT_W-1:0]             depth;
  logic [NODE_W-1:0]            walk_node;
  logic signed [COORD_BITS-1:0] px, py, pz;
  logic [RAD_W-1:0]             rad;

  // Plane test pipeline
  logic signed [PROD_W-1:0] p0, p1, p2;
  logic signed [OFR_W-1:0]  ofr;
  logic signed [DIST_W-1:0] sa, sb, plane_sum;
  logic                     go_front;
  logic signed [LINK_W-1:0] link;

  // Finish path
  logic              accept;
  logic              slot_free;
  logic              rsp_load;
  logic              fin;
  status_t           fin_status;
  logic [CELL_W-1:0] fin_cell;
  logic [CNT_W-1:0]  fin_depth;
  status_t           res_status;
  logic [CELL_W-1:0] res_cell;
  logic [CNT_W-1:0]  res_depth;

  // Node count register
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= '0;
    end else if (cfg_we) begin
      node_count <= cfg_wdata;
    end
  end

  assign limit = (node_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign slot_free = !rsp.valid || rsp.ready;
  // response register takes a new item this cycle
  assign rsp_load  = slot_free && (fin || (state == S_HOLD));

  // Table write port data
  assign mem_we = accept && (req.cmd == CMD_WRITE);
  always_comb begin
    mem_wdata.normal_x     = req.normal_x;
    mem_wdata.normal_y     = req.normal_y;
    mem_wdata.normal_z     = req.normal_z;
    mem_wdata.plane_offset = req.plane_offset;
    mem_wdata.front_link   = req.front_link;
    mem_wdata.back_link    = req.back_link;
  end

  // Node table: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[req.node_index] <= mem_wdata;
    end
    if (state == S_RD) begin
      rd_data <= mem[walk_node];
    end
  end

  // Plane decision and link choice
  assign plane_sum = sa + sb;
  assign go_front  = !plane_sum[DIST_W-1] && (plane_sum != '0);
  assign link      = go_front ? rd_data.front_link : rd_data.back_link;

  // Result of the item that ends this cycle
  always_comb begin
    fin        = 1'b0;
    fin_status = ST_WRITE;
    fin_cell   = '0;
    fin_depth  = '0;
    unique case (state)
      S_IDLE: begin
        if (accept && (req.cmd == CMD_WRITE)) begin
          fin = 1'b1;
        end else if (accept && (limit == '0)) begin
          fin        = 1'b1;
          fin_status = ST_EMPTY;
        end
      end
      S_RD: begin
        if (depth == limit_q) begin
          fin        = 1'b1;
          fin_status = ST_LIMIT;
          fin_depth  = depth;
        end
      end
      S_DEC: begin
        fin_depth = depth;
        if (link == '0) begin
          fin        = 1'b1;
          fin_status = ST_ZERO;
        end else if (link[LINK_W-1]) begin
          fin        = 1'b1;
          fin_status = ST_FOUND;
          fin_cell   = CELL_W'(~link);
        end
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  // Sequencer, walk datapath and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp.valid <= 1'b0;
      depth     <= '0;
      walk_node <= '0;
      limit_q   <= '0;
    end else begin
      if (rsp.valid && rsp.ready && !rsp_load) begin
        rsp.valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept && (req.cmd == CMD_QUERY) && (limit != '0)) begin
            state     <= S_RD;
            limit_q   <= limit;
            depth     <= '0;
            walk_node <= '0;
            px        <= req.point_x;
            py        <= req.point_y;
            pz        <= req.point_z;
            rad       <= req.radius;
          end
        end
        S_RD: begin
          if (!fin) begin
            depth <= depth + 1'b1;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          p0    <= rd_data.normal_x * px;
          p1    <= rd_data.normal_y * py;
          p2    <= rd_data.normal_z * pz;
          ofr   <= {rd_data.plane_offset[OFS_W-1], rd_data.plane_offset}
                 + {{(OFR_W-RAD_W){1'b0}}, rad};
          state <= S_ADD;
        end
        S_ADD: begin
          sa    <= DIST_W'(p0) + DIST_W'(p1);
          sb    <= DIST_W'(p2) + DIST_W'($signed({ofr, {FRAC_BITS{1'b0}}}));
          state <= S_DEC;
        end
        S_DEC: begin
          if (!fin) begin
            walk_node <= NODE_W'(link);
            state     <= S_RD;
          end
        end
        S_HOLD: begin
          if (slot_free) begin
            rsp.valid      <= 1'b1;
            rsp.status     <= res_status;
            rsp.cell_index <= res_cell;
            rsp.walk_depth <= res_depth;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // Deliver a finished item, or park it until the response slot frees
      if (fin) begin
        if (slot_free) begin
          rsp.valid      <= 1'b1;
          rsp.status     <= fin_status;
          rsp.cell_index <= fin_cell;
          rsp.walk_depth <= fin_depth;
          state          <= S_IDLE;
        end else begin
          res_status <= fin_status;
          res_cell   <= fin_cell;
          res_depth  <= fin_depth;
          state      <= S_HOLD;
        end
      end
    end
  end

  // Checks
  `ASSERT_CLK(a_no_write_in_walk, clk, rst, mem_we |-> (state == S_IDLE), "table write during walk")
  `ASSERT_CLK(a_depth_bound, clk, rst, (state != S_IDLE) |-> (depth <= limit_q), "walk depth above limit")
  `ASSERT_CLK(a_limit_depth, clk, rst, (fin && (fin_status == ST_LIMIT)) |-> (fin_depth == limit_q), "walk limit with wrong depth")
  `ASSERT_CLK(a_query_starts, clk, rst, (accept && (req.cmd == CMD_QUERY) && (limit != '0)) |=> (state == S_RD), "query did not start walk")
  `ASSERT_CLK(a_write_rsp, clk, rst, (rsp.valid && (rsp.status == ST_WRITE)) |-> ((rsp.walk_depth == '0) && (rsp.cell_index == '0)), "write result not zero")

endmodule
